/* hdl/system_mgmt_key_read_port_macros.svh */
// Assertion macros for the key read port RTL.
`ifndef SYSTEM_MGMT_KEY_READ_PORT_MACROS_SVH
`define SYSTEM_MGMT_KEY_READ_PORT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SKRP_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("skrp: invariant violated");
`define SKRP_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("skrp: sequence violated");
`else
`define SKRP_ASSERT(lbl, clk, rst_n, prop)
`define SKRP_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

/* hdl/skrp_pkg.sv */
// Shared types, port codes and key tables for the key read port.
`timescale 1ns / 1ps
package skrp_pkg;

	localparam logic [15:0] PORT_DATA = 16'h0300;
	localparam logic [15:0] PORT_CMD  = 16'h0304;
	localparam logic [15:0] PORT_ERR  = 16'h031e;

	localparam logic [7:0] CMD_READ = 8'h10;

	localparam logic [7:0] ST_DONE  = 8'h00;
	localparam logic [7:0] ST_READY = 8'h01;
	localparam logic [7:0] ST_ACK   = 8'h04;
	localparam logic [7:0] ST_NEW   = 8'h08;

	localparam logic [7:0] ER_NONE  = 8'h00;
	localparam logic [7:0] ER_INTR  = 8'h80;
	localparam logic [7:0] ER_STILL = 8'h81;
	localparam logic [7:0] ER_BAD   = 8'h82;
	localparam logic [7:0] ER_NOKEY = 8'h84;

	localparam int NUM_KEYS = 6;

	typedef enum logic [2:0] {
		KEY_REV  = 3'd0,
		KEY_NATJ = 3'd1,
		KEY_MSSP = 3'd2,
		KEY_MSSD = 3'd3,
		KEY_OSK0 = 3'd4,
		KEY_OSK1 = 3'd5
	} key_id_t;

	// first character in the top byte
	localparam logic [31:0] KEY_NAMES [NUM_KEYS] = '{
		"REV ", "NATJ", "MSSP", "MSSD", "OSK0", "OSK1"
	};
	localparam logic [5:0] KEY_LENS [NUM_KEYS] = '{
		6'd6, 6'd1, 6'd1, 6'd1, 6'd32, 6'd32
	};
	localparam logic [7:0] REV_BYTES [6] = '{
		8'h01, 8'h13, 8'h0f, 8'h00, 8'h00, 8'h03
	};

	typedef struct packed {
		logic        action;
		logic [15:0] port_address;
		logic [7:0]  write_value;
	} req_t;

	localparam logic ACT_WRITE = 1'b1;

	// fixed-table key contents
	function automatic logic [7:0] rom_byte(key_id_t k, logic [5:0] pos);
		logic [7:0] b;
		b = 8'h00;
		case (k)
			KEY_REV:  if (pos < 6'd6) b = REV_BYTES[pos[2:0]];
			KEY_MSSD: if (pos == 6'd0) b = 8'h03;
			default:  b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

/* hdl/skrp_osk_regs.sv */
// Configuration registers holding the 64-byte key, with byte select.
`timescale 1ns / 1ps
module skrp_osk_regs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic [5:0]  byte_index,
	output logic [7:0]  key_byte
);
	import skrp_pkg::*;

	logic [63:0] word_q [8];
	logic [63:0] sel_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) word_q[i] <= '0;
		end else if (cfg_we) begin
			word_q[cfg_index] <= cfg_data;
		end
	end

	assign sel_word = word_q[byte_index[5:3]];
	assign key_byte = sel_word[{byte_index[2:0], 3'b000} +: 8];

endmodule

/* hdl/skrp_core.sv */
// Command/status protocol state and per-access update logic.
`timescale 1ns / 1ps
`include "system_mgmt_key_read_port_macros.svh"
module skrp_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  skrp_pkg::req_t req,
	input  logic [7:0]    osk_byte,
	output logic [5:0]    osk_index,
	output logic [7:0]    result
);
	import skrp_pkg::*;

	logic [7:0] cmd_q, status_q, error_q, last_q;
	logic [2:0] wc_q;
	key_id_t    sel_q;
	logic [5:0] len_q, pos_q;
	logic [7:0] kb_q [4];

	logic [7:0] cmd_d, status_d, error_d, last_d;
	logic [2:0] wc_d;
	key_id_t    sel_d;
	logic [5:0] len_d, pos_d;
	logic       kb_we;

	logic       is_data, is_cmd, is_err, is_wr, cmd_ok, busy;
	logic       found;
	key_id_t    found_id;
	logic [31:0] name;
	logic [7:0] key_byte;
	logic [5:0] pos_inc;

	assign is_data = req.port_address == PORT_DATA;
	assign is_cmd  = req.port_address == PORT_CMD;
	assign is_err  = req.port_address == PORT_ERR;
	assign is_wr   = req.action == ACT_WRITE;
	assign cmd_ok  = cmd_q == CMD_READ;
	assign busy    = status_q[3:0] != ST_DONE[3:0];
	assign name    = {kb_q[0], kb_q[1], kb_q[2], kb_q[3]};
	assign pos_inc = pos_q + 6'd1;

	assign osk_index = {sel_q == KEY_OSK1, pos_q[4:0]};
	assign key_byte  = (sel_q == KEY_OSK0 || sel_q == KEY_OSK1) ?
		osk_byte : rom_byte(sel_q, pos_q);

	always_comb begin
		found    = 1'b0;
		found_id = KEY_REV;
		for (int k = NUM_KEYS - 1; k >= 0; k--) begin
			if (name == KEY_NAMES[k]) begin
				found    = 1'b1;
				found_id = key_id_t'(3'(k));
			end
		end
	end

	always_comb begin
		cmd_d    = cmd_q;
		status_d = status_q;
		error_d  = error_q;
		last_d   = last_q;
		wc_d     = wc_q;
		sel_d    = sel_q;
		len_d    = len_q;
		pos_d    = pos_q;
		kb_we    = 1'b0;
		result   = 8'h00;
		if (!is_wr) begin
			if (is_cmd) begin
				result = status_q;
			end else if (is_err) begin
				result = error_q;
			end else if (is_data) begin
				if (!cmd_ok) begin
					status_d = ST_DONE;
					error_d  = ER_STILL;
				end else if (status_q[0] && pos_q < len_q) begin
					last_d   = key_byte;
					pos_d    = pos_inc;
					status_d = (pos_inc == len_q) ? ST_DONE : (ST_ACK | ST_READY);
				end
				result = last_d;
			end
		end else if (is_cmd) begin
			if (req.write_value == CMD_READ) begin
				if (status_q[3:0] == ST_DONE[3:0] || status_q[3:0] == ST_NEW[3:0]) begin
					cmd_d    = req.write_value;
					status_d = ST_NEW | ST_ACK;
				end else begin
					status_d = ST_NEW;
					error_d  = ER_INTR;
				end
			end else begin
				status_d = ST_NEW;
				error_d  = ER_BAD;
			end
			wc_d  = 3'd0;
			pos_d = 6'd0;
		end else if (is_data) begin
			if (!cmd_ok) begin
				status_d = ST_DONE;
				error_d  = ER_STILL;
			end else if (busy) begin
				if (wc_q < 3'd4) begin
					kb_we    = 1'b1;
					status_d = ST_ACK;
				end else if (wc_q == 3'd4) begin
					if (found) begin
						sel_d    = found_id;
						len_d    = KEY_LENS[found_id];
						pos_d    = 6'd0;
						status_d = ST_ACK | ST_READY;
						error_d  = ER_NONE;
					end else begin
						status_d = ST_DONE;
						error_d  = ER_NOKEY;
					end
				end
				if (wc_q < 3'd5) wc_d = wc_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q    <= 8'h00;
			status_q <= ST_DONE;
			error_q  <= ER_NONE;
			last_q   <= 8'h00;
			wc_q     <= 3'd0;
			sel_q    <= KEY_REV;
			len_q    <= 6'd0;
			pos_q    <= 6'd0;
		end else if (fire) begin
			cmd_q    <= cmd_d;
			status_q <= status_d;
			error_q  <= error_d;
			last_q   <= last_d;
			wc_q     <= wc_d;
			sel_q    <= sel_d;
			len_q    <= len_d;
			pos_q    <= pos_d;
		end
	end

	// key name bytes: no reset, always written before a lookup
	always_ff @(posedge clk) begin
		if (fire && kb_we) kb_q[wc_q[1:0]] <= req.write_value;
	end

	`SKRP_ASSERT(a_wc_sat, clk, arst_n, wc_q <= 3'd5)
	`SKRP_ASSERT(a_pos_in_range, clk, arst_n, pos_q <= len_q)
	`SKRP_ASSERT(a_ready_needs_cmd, clk, arst_n, !status_q[0] || cmd_q == CMD_READ)
	`SKRP_ASSERT_NEXT(a_idle_hold, clk, arst_n, !fire, $stable(wc_q) && $stable(pos_q))

endmodule

/* hdl/system_mgmt_key_read_port.sv */
// Top level of the management key read port: handshake stages and key registers.
//
// Usage:
//   Each request on the input channel (in_valid/in_ready) is one byte bus access:
//   action (0 read, 1 write), port_address and write_value. Every request gives
//   exactly one response byte, read_data, on the output channel
//   (out_valid/out_ready); writes and unknown ports return zero.
//   The 64-byte key is loaded through cfg_we/cfg_index/cfg_data, one 64-bit
//   word per write, while no request is in flight.
// Timing:
//   A request is captured in an input register; the protocol update then loads the
//   output register, which raises out_valid, once the output stage can advance.
//   One request per cycle is sustained while out_ready stays high; the protocol
//   update is a single pass of logic between the two registers.
// Reset:
//   arst_n clears both stages, the protocol state (status done, no error) and
//   the key registers.
// Stall:
//   While out_ready is low the response holds; one further request may sit in
//   the input register, after which in_ready drops.
`timescale 1ns / 1ps
module system_mgmt_key_read_port (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [15:0] port_address,
	input  logic [7:0]  write_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_data,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import skrp_pkg::*;

	logic       valid_s1, valid_s2;
	req_t       req_s1;
	logic [7:0] data_s2;
	logic       adv, fire;
	logic [7:0] result;
	logic [5:0] osk_index;
	logic [7:0] osk_byte;

	assign adv      = !valid_s2 || out_ready;
	assign fire     = valid_s1 && adv;
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (fire) valid_s2 <= 1'b1;
			else if (out_ready) valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1.action       <= action;
			req_s1.port_address <= port_address;
			req_s1.write_value  <= write_value;
		end
		if (fire) data_s2 <= result;
	end

	skrp_osk_regs u_osk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.byte_index (osk_index),
		.key_byte   (osk_byte)
	);

	skrp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.req       (req_s1),
		.osk_byte  (osk_byte),
		.osk_index (osk_index),
		.result    (result)
	);

	assign out_valid = valid_s2;
	assign read_data = data_s2;

endmodule
